### hw/rtl/ucl_pkg.sv
package ucl_pkg;

    localparam logic [31:0] NOMINAL_RESET = 32'd100000000;
    localparam logic [29:0] NS_PER_S      = 30'd1000000000;
    localparam logic [31:0] DIV_1000      = 32'd1000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CALIB = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // register indexes of the configuration port
    localparam logic [0:0] REG_NOMINAL = 1'b0;
    localparam logic [0:0] REG_OFFSET  = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] new_freq_hz;
    } in_t;

    typedef struct packed {
        logic [62:0]        uptime_us;
        logic [62:0]        uptime_ms;
        logic signed [63:0] unix_us;
        logic signed [63:0] unix_ms;
        logic [31:0]        freq_in_use_hz;
    } out_t;

    typedef struct packed {
        logic        nom_wr;
        logic [31:0] nom_val;
    } cfg_evt_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DQ_GO,
        ST_DQ_WAIT,
        ST_MUL_R,
        ST_DN_GO,
        ST_DN_WAIT,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_COMMIT,
        ST_US_GO,
        ST_US_WAIT,
        ST_MS_GO,
        ST_MS_WAIT,
        ST_UX_ADD,
        ST_UX_GO,
        ST_UX_WAIT,
        ST_PUSH
    } st_t;

    // one restoring division step: {quotient bit, new partial remainder}
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic bit_in,
                                             input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] s;
        t = {rem, bit_in};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            div_step = {1'b1, s[31:0]};
        end else begin
            div_step = {1'b0, t[31:0]};
        end
    endfunction

endpackage

### hw/rtl/ucl_div.sv
// 64 / 32 restoring divider, two quotient bits per cycle
module ucl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic [31:0] remainder,
    output logic        busy,
    output logic        done
);
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] s1;
    logic [32:0] s2;

    assign s1 = ucl_pkg::div_step(rem_reg, quo_reg[63], dvs_reg);
    assign s2 = ucl_pkg::div_step(s1[31:0], quo_reg[62], dvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[61:0], s1[32], s2[32]};
            rem_reg <= s2[31:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

### hw/rtl/ucl_apb.sv
// configuration registers: nominal frequency at 0x0, unix offset at 0x8
module ucl_apb (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output logic [63:0]         offset,
    output ucl_pkg::cfg_evt_t   evt
);
    logic [31:0] nom_reg;
    logic [63:0] off_reg;
    logic        wr;
    logic [0:0]  idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[3:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nom_reg <= ucl_pkg::NOMINAL_RESET;
            off_reg <= '0;
        end else if (wr && paddr[2:0] == 3'd0) begin
            if (idx == ucl_pkg::REG_NOMINAL) begin
                nom_reg <= pwdata[31:0];
            end else begin
                off_reg <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:0] == 3'd0) begin
            if (idx == ucl_pkg::REG_NOMINAL) begin
                prdata = {32'd0, nom_reg};
            end else begin
                prdata = off_reg;
            end
        end
    end

    assign evt.nom_wr  = wr && paddr == 4'd0 && pwdata[31:0] != 32'd0;
    assign evt.nom_val = pwdata[31:0];
    assign pready      = 1'b1;
    assign offset      = off_reg;

endmodule

### hw/rtl/calibrated_uptime_clock.sv
// Calibrated uptime clock.
// Input channel s_valid/s_ready/s_data carries one item: cmd and new_freq_hz.
//   tick      : adds one to the 64-bit tick counter; the block stays ready.
//   calibrate : folds the ticks since the base tick into the base time with the
//               old frequency (exact remainder kept), then switches to new_freq_hz.
//               A zero frequency is ignored.
//   read      : one result item on m_valid/m_ready/m_data with uptime and unix
//               time in us and ms and the frequency in use.
//   cmd 3     : dropped.
// One shared divider (two quotient bits per cycle) does all division: two passes
// by the frequency for each calibrate or read, and three passes by 1000 for a read;
// a single 32x30 multiplier covers the scaling.
// s_ready is high only while the sequencer is idle; one item is in work at a time.
// A finished result sits in the output register; if the receiver stalls, the
// block still takes ticks and calibrates, and a following read waits for the slot.
// APB: nominal frequency at 0x0, unix offset at 0x8; a nonzero nominal write
// also becomes the frequency in use. Write only while idle.
// Reset (aresetn low, synchronous) clears counter and time base and loads the
// nominal frequency of 100 MHz.
module calibrated_uptime_clock (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ucl_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ucl_pkg::out_t  m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    ucl_pkg::st_t      state_reg, state_next;
    ucl_pkg::cfg_evt_t evt;
    logic [63:0]       offset;

    logic [63:0] tick_reg, origin_tick_reg, base_time_reg, d_reg;
    logic [31:0] frac_rem_reg, freq_reg, nf_reg;
    logic [1:0]  cmd_reg;
    logic [63:0] q_reg, num_reg, nsq_reg, acc_reg, t_reg, up_us_reg, up_ms_reg, ux_reg;
    logic [31:0] drem_reg;
    logic        neg_reg;
    logic        m_valid_reg;
    ucl_pkg::out_t out_reg;

    logic        div_start, div_busy, div_done;
    logic [63:0] div_quo;
    logic [31:0] div_rem;
    logic [63:0] div_a;
    logic [31:0] div_b;
    logic [63:0] sgn_src;
    logic [63:0] signed_quo;
    logic [31:0] mul_a;
    logic [61:0] prod;
    logic        s_acc, m_acc;

    ucl_apb u_apb (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .offset(offset), .evt(evt)
    );

    ucl_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .quotient(div_quo), .remainder(div_rem),
        .busy(div_busy), .done(div_done)
    );

    assign s_ready = (state_reg == ucl_pkg::ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_acc   = m_valid_reg && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ucl_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_data.cmd == ucl_pkg::CMD_READ ||
                        (s_data.cmd == ucl_pkg::CMD_CALIB && s_data.new_freq_hz != 32'd0)) begin
                        state_next = ucl_pkg::ST_DQ_GO;
                    end
                end
            end
            ucl_pkg::ST_DQ_GO:   state_next = ucl_pkg::ST_DQ_WAIT;
            ucl_pkg::ST_DQ_WAIT: if (div_done) state_next = ucl_pkg::ST_MUL_R;
            ucl_pkg::ST_MUL_R:   state_next = ucl_pkg::ST_DN_GO;
            ucl_pkg::ST_DN_GO:   state_next = ucl_pkg::ST_DN_WAIT;
            ucl_pkg::ST_DN_WAIT: if (div_done) state_next = ucl_pkg::ST_MUL_LO;
            ucl_pkg::ST_MUL_LO:  state_next = ucl_pkg::ST_MUL_HI;
            ucl_pkg::ST_MUL_HI:  state_next = ucl_pkg::ST_SUM;
            ucl_pkg::ST_SUM:     state_next = ucl_pkg::ST_COMMIT;
            ucl_pkg::ST_COMMIT: begin
                if (cmd_reg == ucl_pkg::CMD_READ) begin
                    state_next = ucl_pkg::ST_US_GO;
                end else begin
                    state_next = ucl_pkg::ST_IDLE;
                end
            end
            ucl_pkg::ST_US_GO:   state_next = ucl_pkg::ST_US_WAIT;
            ucl_pkg::ST_US_WAIT: if (div_done) state_next = ucl_pkg::ST_MS_GO;
            ucl_pkg::ST_MS_GO:   state_next = ucl_pkg::ST_MS_WAIT;
            ucl_pkg::ST_MS_WAIT: if (div_done) state_next = ucl_pkg::ST_UX_ADD;
            ucl_pkg::ST_UX_ADD:  state_next = ucl_pkg::ST_UX_GO;
            ucl_pkg::ST_UX_GO:   state_next = ucl_pkg::ST_UX_WAIT;
            ucl_pkg::ST_UX_WAIT: if (div_done) state_next = ucl_pkg::ST_PUSH;
            ucl_pkg::ST_PUSH:    if (!m_valid_reg || m_ready) state_next = ucl_pkg::ST_IDLE;
            default:             state_next = ucl_pkg::ST_IDLE;
        endcase
    end

    // datapath controls: divider operands and multiplier input
    always_comb begin
        div_start = 1'b0;
        div_b     = freq_reg;
        sgn_src   = t_reg;
        mul_a     = drem_reg;
        case (state_reg)
            ucl_pkg::ST_DQ_GO, ucl_pkg::ST_DN_GO:        div_start = 1'b1;
            ucl_pkg::ST_US_GO: begin
                div_start = 1'b1;
                div_b     = ucl_pkg::DIV_1000;
            end
            ucl_pkg::ST_MS_GO: begin
                div_start = 1'b1;
                div_b     = ucl_pkg::DIV_1000;
                sgn_src   = up_us_reg;
            end
            ucl_pkg::ST_UX_GO: begin
                div_start = 1'b1;
                div_b     = ucl_pkg::DIV_1000;
                sgn_src   = ux_reg;
            end
            ucl_pkg::ST_MS_WAIT: sgn_src = up_us_reg;
            ucl_pkg::ST_UX_WAIT: sgn_src = ux_reg;
            ucl_pkg::ST_MUL_R:   mul_a = drem_reg;
            ucl_pkg::ST_MUL_LO:  mul_a = q_reg[31:0];
            ucl_pkg::ST_MUL_HI:  mul_a = q_reg[63:32];
            default: ;
        endcase
    end

    always_comb begin
        case (state_reg)
            ucl_pkg::ST_DQ_GO: div_a = tick_reg - origin_tick_reg;
            ucl_pkg::ST_DN_GO: div_a = num_reg;
            default:           div_a = sgn_src[63] ? (64'd0 - sgn_src) : sgn_src;
        endcase
    end

    assign prod       = mul_a * ucl_pkg::NS_PER_S;
    assign signed_quo = neg_reg ? (64'd0 - div_quo) : div_quo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ucl_pkg::ST_IDLE;
            tick_reg        <= '0;
            origin_tick_reg <= '0;
            base_time_reg   <= '0;
            frac_rem_reg    <= '0;
            freq_reg        <= ucl_pkg::NOMINAL_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (evt.nom_wr) begin
                freq_reg <= evt.nom_val;
            end
            if (s_acc && s_data.cmd == ucl_pkg::CMD_TICK) begin
                tick_reg <= tick_reg + 64'd1;
            end
            if (state_reg == ucl_pkg::ST_COMMIT && cmd_reg == ucl_pkg::CMD_CALIB) begin
                base_time_reg   <= base_time_reg + acc_reg;
                frac_rem_reg    <= drem_reg;
                origin_tick_reg <= tick_reg;
                freq_reg        <= nf_reg;
            end
            if (state_reg == ucl_pkg::ST_PUSH && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_acc) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= s_data.cmd;
            nf_reg  <= s_data.new_freq_hz;
        end
        if (div_start) begin
            neg_reg <= sgn_src[63];
        end
        case (state_reg)
            ucl_pkg::ST_DQ_WAIT: if (div_done) begin
                q_reg    <= div_quo;
                drem_reg <= div_rem;
            end
            ucl_pkg::ST_MUL_R:   num_reg <= {2'b00, prod} + {32'd0, frac_rem_reg};
            ucl_pkg::ST_DN_WAIT: if (div_done) begin
                nsq_reg  <= div_quo;
                drem_reg <= div_rem;
            end
            ucl_pkg::ST_MUL_LO:  acc_reg <= {2'b00, prod};
            ucl_pkg::ST_MUL_HI:  acc_reg <= acc_reg + {prod[31:0], 32'd0};
            ucl_pkg::ST_SUM:     acc_reg <= acc_reg + nsq_reg;
            ucl_pkg::ST_COMMIT:  t_reg <= base_time_reg + acc_reg;
            ucl_pkg::ST_US_WAIT: if (div_done) up_us_reg <= signed_quo;
            ucl_pkg::ST_MS_WAIT: if (div_done) up_ms_reg <= signed_quo;
            ucl_pkg::ST_UX_ADD:  ux_reg <= up_us_reg + offset;
            ucl_pkg::ST_UX_WAIT: if (div_done) d_reg <= signed_quo;
            ucl_pkg::ST_PUSH: if (!m_valid_reg || m_ready) begin
                out_reg.uptime_us      <= up_us_reg[62:0];
                out_reg.uptime_ms      <= up_ms_reg[62:0];
                out_reg.unix_us        <= ux_reg;
                out_reg.unix_ms        <= d_reg;
                out_reg.freq_in_use_hz <= freq_reg;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_freq_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        freq_reg != 32'd0) else $error("frequency in use is zero");

    a_tick_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.cmd == ucl_pkg::CMD_TICK) |=> tick_reg == $past(tick_reg) + 64'd1)
        else $error("tick not counted");

    a_start_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider started while busy");

    a_push_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ucl_pkg::ST_PUSH && state_next == ucl_pkg::ST_IDLE) |=> m_valid_reg)
        else $error("result not presented");

endmodule
